// File: rtl/fps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fps_pkg
// Shared types, codes and the phase entry function of the flight phase
// sequencer.
// ----------------------------------------------------------------------------
package fps_pkg;

    // Phase codes.
    localparam logic [2:0] PH_SAFETY    = 3'd0;
    localparam logic [2:0] PH_READY     = 3'd1;
    localparam logic [2:0] PH_BURNING   = 3'd2;
    localparam logic [2:0] PH_FLIGHT    = 3'd3;
    localparam logic [2:0] PH_SEP       = 3'd4;
    localparam logic [2:0] PH_LANDED    = 3'd5;
    localparam logic [2:0] PH_EMERGENCY = 3'd6;

    // Separation cause codes.
    localparam logic [1:0] CAUSE_NONE    = 2'd0;
    localparam logic [1:0] CAUSE_TIMEOUT = 2'd1;
    localparam logic [1:0] CAUSE_APEX    = 2'd2;
    localparam logic [1:0] CAUSE_COMMAND = 2'd3;

    // Event kinds.
    localparam logic [2:0] REQ_PIN     = 3'd0;
    localparam logic [2:0] REQ_FLIGHT  = 3'd1;
    localparam logic [2:0] REQ_SEP     = 3'd2;
    localparam logic [2:0] REQ_APEX    = 3'd3;
    localparam logic [2:0] REQ_MISSION = 3'd4;
    localparam logic [2:0] REQ_CMD     = 3'd5;

    // Uplink command codes.
    localparam logic [7:0] CMD_BACK      = 8'd0;
    localparam logic [7:0] CMD_FORWARD   = 8'd1;
    localparam logic [7:0] CMD_EMERGENCY = 8'd6;

    // Configuration register indexes.
    localparam logic [2:0] REG_BURN_TICKS   = 3'd0;
    localparam logic [2:0] REG_APEX_TIMEOUT = 3'd1;
    localparam logic [2:0] REG_SEP_HOLD     = 3'd2;
    localparam logic [2:0] REG_NODE_ID      = 3'd3;
    localparam logic [2:0] REG_RISE_COUNT   = 3'd4;

    localparam int ADDR_W = 5;
    localparam int IN_W   = 48;
    localparam int OUT_W  = 64;

    typedef struct packed {
        logic [15:0] burn_ticks;
        logic [15:0] apex_timeout_ticks;
        logic [15:0] sep_hold_ticks;
        logic [7:0]  own_node_id;
        logic [3:0]  apex_rise_count;
    } fps_cfg_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic [1:0]  cause;
        logic        sep_drive;
        logic        pin_watch_on;
        logic        flight_timer_on;
        logic        sep_timer_on;
        logic        apex_watch_on;
        logic [15:0] mission_count;
        logic [31:0] flight_count;
        logic [31:0] sep_count;
        logic [3:0]  rise_count;
        logic [24:0] last_pressure;
    } fps_state_t;

    typedef struct packed {
        logic [2:0]  req_type;
        logic        launch_pin_level;
        logic [24:0] pressure_sample;
        logic [7:0]  dest_node;
        logic [7:0]  command_code;
    } fps_event_t;

    // Moves to a new phase; a real change of phase runs that phase's entry action.
    function automatic fps_state_t go_phase(input fps_state_t cur, input logic [2:0] nxt);
        fps_state_t s;
        s = cur;
        if (nxt != cur.phase)
        begin
            s.phase = nxt;
            case (nxt)
                PH_READY:   s.pin_watch_on = 1'b1;
                PH_BURNING: s.flight_timer_on = 1'b1;
                PH_FLIGHT:  s.apex_watch_on = 1'b1;
                PH_SEP:
                begin
                    s.sep_drive    = 1'b1;
                    s.sep_timer_on = 1'b1;
                end
                default: ;
            endcase
        end
        return s;
    endfunction

endpackage
`default_nettype wire

// File: rtl/fps_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fps_cfg
// APB-style configuration register file for the flight phase sequencer.
// ----------------------------------------------------------------------------
module fps_cfg
    import fps_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output fps_cfg_t               cfg
);

    fps_cfg_t   cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.burn_ticks         <= 16'd30;
            cfg_reg.apex_timeout_ticks <= 16'd150;
            cfg_reg.sep_hold_ticks     <= 16'd50;
            cfg_reg.own_node_id        <= 8'd3;
            cfg_reg.apex_rise_count    <= 4'd10;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_BURN_TICKS:   cfg_reg.burn_ticks         <= pwdata[15:0];
                REG_APEX_TIMEOUT: cfg_reg.apex_timeout_ticks <= pwdata[15:0];
                REG_SEP_HOLD:     cfg_reg.sep_hold_ticks     <= pwdata[15:0];
                REG_NODE_ID:      cfg_reg.own_node_id        <= pwdata[7:0];
                REG_RISE_COUNT:   cfg_reg.apex_rise_count    <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_BURN_TICKS:   prdata = {16'd0, cfg_reg.burn_ticks};
            REG_APEX_TIMEOUT: prdata = {16'd0, cfg_reg.apex_timeout_ticks};
            REG_SEP_HOLD:     prdata = {16'd0, cfg_reg.sep_hold_ticks};
            REG_NODE_ID:      prdata = {24'd0, cfg_reg.own_node_id};
            REG_RISE_COUNT:   prdata = {28'd0, cfg_reg.apex_rise_count};
            default:          prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/fps_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fps_core
// Next-state logic: applies one event to the sequencer state.
// ----------------------------------------------------------------------------
module fps_core
    import fps_pkg::*;
(
    input  wire fps_cfg_t   cfg,
    input  wire fps_state_t cur,
    input  wire fps_event_t ev,
    output fps_state_t      nxt
);

    always_comb
    begin
        fps_state_t s;
        s = cur;
        case (ev.req_type)
            REQ_PIN:
            begin
                if (s.pin_watch_on && ev.launch_pin_level)
                begin
                    s.pin_watch_on = 1'b0;
                    s = go_phase(s, PH_BURNING);
                end
            end
            REQ_FLIGHT:
            begin
                if (s.flight_timer_on)
                begin
                    s.flight_count = s.flight_count + 32'd1;
                    if (s.phase == PH_BURNING)
                    begin
                        if (s.flight_count >= {16'd0, cfg.burn_ticks})
                            s = go_phase(s, PH_FLIGHT);
                    end
                    else if (s.phase == PH_FLIGHT)
                    begin
                        if (s.flight_count >= {16'd0, cfg.apex_timeout_ticks})
                        begin
                            s = go_phase(s, PH_SEP);
                            s.cause = CAUSE_TIMEOUT;
                        end
                    end
                end
            end
            REQ_SEP:
            begin
                if (s.sep_timer_on)
                begin
                    s.sep_count = s.sep_count + 32'd1;
                    if (s.phase == PH_SEP && s.sep_count >= {16'd0, cfg.sep_hold_ticks})
                    begin
                        s.sep_timer_on = 1'b0;
                        s.sep_drive    = 1'b0;
                        s = go_phase(s, PH_LANDED);
                    end
                end
            end
            REQ_APEX:
            begin
                if (s.apex_watch_on && s.phase == PH_FLIGHT)
                begin
                    if (s.last_pressure <= ev.pressure_sample)
                    begin
                        s.rise_count = s.rise_count + 4'd1;
                        if (s.rise_count >= cfg.apex_rise_count)
                        begin
                            s.apex_watch_on = 1'b0;
                            s = go_phase(s, PH_SEP);
                            s.cause      = CAUSE_APEX;
                            s.rise_count = 4'd0;
                        end
                    end
                    else
                    begin
                        s.rise_count = 4'd0;
                    end
                    s.last_pressure = ev.pressure_sample;
                end
            end
            REQ_MISSION:
            begin
                s.mission_count = s.mission_count + 16'd1;
            end
            REQ_CMD:
            begin
                if (ev.dest_node == cfg.own_node_id)
                begin
                    case (ev.command_code)
                        CMD_BACK:
                        begin
                            if (cur.phase == PH_READY)
                                s = go_phase(s, PH_SAFETY);
                            else if (cur.phase == PH_BURNING)
                                s = go_phase(s, PH_READY);
                            else if (cur.phase == PH_LANDED)
                                s = go_phase(s, PH_SEP);
                        end
                        CMD_FORWARD:
                        begin
                            if (cur.phase == PH_SAFETY)
                                s = go_phase(s, PH_READY);
                            else if (cur.phase == PH_FLIGHT)
                            begin
                                s = go_phase(s, PH_SEP);
                                s.cause = CAUSE_COMMAND;
                            end
                            else if (cur.phase == PH_LANDED)
                                s = go_phase(s, PH_EMERGENCY);
                            else if (cur.phase == PH_EMERGENCY)
                            begin
                                s = go_phase(s, PH_SAFETY);
                                s.flight_timer_on = 1'b0;
                                s.flight_count    = 32'd0;
                            end
                        end
                        CMD_EMERGENCY:
                        begin
                            if (cur.phase != PH_SAFETY)
                                s = go_phase(s, PH_EMERGENCY);
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        nxt = s;
    end

endmodule
`default_nettype wire

// File: rtl/fps_skid.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fps_skid
// Two-entry result buffer: an output register backed by one skid register.
// ----------------------------------------------------------------------------
module fps_skid
    import fps_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [OUT_W-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic      [OUT_W-1:0] out_data
);

    logic             out_valid_reg;
    logic             out_valid_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    logic [OUT_W-1:0] out_data_reg;
    logic [OUT_W-1:0] out_data_next;
    logic [OUT_W-1:0] skid_data_reg;
    logic [OUT_W-1:0] skid_data_next;
    logic             push;
    logic             pop;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign push      = in_valid & in_ready;
    assign pop       = out_valid_reg & out_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_data_next  = in_data;
                skid_valid_next = 1'b1;
            end
            else
            begin
                out_data_next  = in_data;
                out_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule
`default_nettype wire

// File: rtl/flight_phase_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// The result of an accepted event is registered in the result buffer before m_tdata.
// Throughput: one event per cycle while s_tready is high; the state update loop sets this.
// A two-entry result buffer keeps s_tready high while one result waits on m_tready.
// Reset (rst_n, asynchronous, active low) puts the sequencer in the safety phase with
// all watchers off and counters zero, and loads the register defaults.
// ----------------------------------------------------------------------------
// flight_phase_sequencer
// Rocket flight phase sequencer: steps through safety, ready, burning, flight,
// separation, landed and emergency in response to one event per transaction.
// ----------------------------------------------------------------------------
module flight_phase_sequencer
    import fps_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // Event stream.
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // [0] launch_pin_level, [25:1] pressure_sample, [33:26] dest_node,
    // [41:34] command_code, [47:42] zero.
    input  wire logic [IN_W-1:0]   s_tdata,
    // [2:0] req_type.
    input  wire logic [2:0]        s_tuser,
    // Result stream.
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // [2:0] phase, [4:3] sep_cause, [5] sep_output, [21:6] mission_ticks,
    // [53:22] flight_ticks, [57:54] rise_run, [63:58] zero.
    output logic      [OUT_W-1:0]  m_tdata,
    // Configuration port.
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    fps_cfg_t         cfg;
    fps_state_t       state_reg;
    fps_state_t       state_next;
    fps_event_t       ev;
    logic             accept;
    logic [OUT_W-1:0] result;

    // Register file.
    fps_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Unpack the event from the stream payload.
    assign ev.req_type         = s_tuser;
    assign ev.launch_pin_level = s_tdata[0];
    assign ev.pressure_sample  = s_tdata[25:1];
    assign ev.dest_node        = s_tdata[33:26];
    assign ev.command_code     = s_tdata[41:34];

    // The whole event is applied by the combinational next-state logic.
    fps_core u_core (
        .cfg (cfg),
        .cur (state_reg),
        .ev  (ev),
        .nxt (state_next)
    );

    assign accept = s_tvalid & s_tready;

    // Sequencer state only moves on an accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    // The result reflects the state after the event has been applied.
    assign result = {6'd0,
                     state_next.rise_count,
                     state_next.flight_count,
                     state_next.mission_count,
                     state_next.sep_drive,
                     state_next.cause,
                     state_next.phase};

    fps_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule
`default_nettype wire
